// ===== hdl/assert_macros.svh =====
// assertion helpers for the rtl, included by lbbp_back.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== hdl/lbbp_pkg.sv =====
package lbbp_pkg;

  localparam int BLOCKS_DEF   = 16;
  localparam int AGE_BITS_DEF = 16;
  localparam int QUEUE_DEPTH  = 2;

  localparam int CMD_W   = 2;
  localparam int FILE_W  = 3;
  localparam int BLOCK_W = 20;
  localparam int KIND_W  = 3;
  localparam int SLOT_W  = 4;

  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd2;

  typedef enum logic [1:0] {
    OP_READ,
    OP_ALLOC,
    OP_CLOSE
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    K_HIT    = 3'd0,
    K_WB     = 3'd1,
    K_FILL   = 3'd2,
    K_ALLOC  = 3'd3,
    K_CLOSE  = 3'd4,
    K_NOVICT = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AGE,
    S_SCAN,
    S_DECIDE,
    S_FIN,
    S_CSCAN,
    S_CEND
  } state_e;

  typedef struct packed {
    op_e                op;
    logic [FILE_W-1:0]  file;
    logic [BLOCK_W-1:0] block;
    logic               dirty;
    logic               pin;
  } req_t;

  typedef struct packed {
    kind_e              kind;
    logic [SLOT_W-1:0]  slot;
    logic [FILE_W-1:0]  file;
    logic [BLOCK_W-1:0] block;
    logic               last;
  } res_t;

endpackage

// ===== hdl/lbbp_fifo.sv =====
module lbbp_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_i,
  input  logic [W-1:0] wdata_i,
  output logic         full_o,
  input  logic         rd_i,
  output logic [W-1:0] rdata_o,
  output logic         empty_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_wr, do_rd;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_wr) begin
      wp_d = (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
    if (do_rd) begin
      rp_d = (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

endmodule

// ===== hdl/lbbp_front.sv =====
module lbbp_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [lbbp_pkg::CMD_W-1:0]    cmd_i,
  input  logic [lbbp_pkg::FILE_W-1:0]   file_id_i,
  input  logic [lbbp_pkg::BLOCK_W-1:0]  block_num_i,
  input  logic                          mark_dirty_i,
  input  logic                          pin_i,
  output logic                          req_valid_o,
  output lbbp_pkg::req_t                req_o,
  input  logic                          req_pop_i
);
  import lbbp_pkg::*;

  req_t req_in;
  logic known;
  logic empty;
  logic [$bits(req_t)-1:0] rdata;

  // unknown commands are dropped here and never reach the back end
  always_comb begin
    known = 1'b1;
    req_in.op = OP_READ;
    case (cmd_i)
      CMD_READ:  req_in.op = OP_READ;
      CMD_ALLOC: req_in.op = OP_ALLOC;
      CMD_CLOSE: req_in.op = OP_CLOSE;
      default:   known = 1'b0;
    endcase
    req_in.file  = file_id_i;
    req_in.block = block_num_i;
    req_in.dirty = mark_dirty_i;
    req_in.pin   = pin_i;
  end

  lbbp_fifo #(
    .W     ($bits(req_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_req_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push && known),
    .wdata_i (req_in),
    .full_o  (full),
    .rd_i    (req_pop_i),
    .rdata_o (rdata),
    .empty_o (empty)
  );

  assign req_valid_o = !empty;
  assign req_o       = req_t'(rdata);

endmodule

// ===== hdl/lbbp_back.sv =====
`include "assert_macros.svh"
module lbbp_back #(
  parameter int BLOCKS   = lbbp_pkg::BLOCKS_DEF,
  parameter int AGE_BITS = lbbp_pkg::AGE_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  lbbp_pkg::req_t req_i,
  output logic           req_pop_o,
  input  logic           out_full_i,
  output logic           push_o,
  output lbbp_pkg::res_t res_o
);
  import lbbp_pkg::*;

  localparam int IW = $clog2(BLOCKS);
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  state_e st_q, st_d;
  req_t   req_q;
  logic [IW-1:0] cur_q;

  logic                valid_q [BLOCKS];
  logic                dirty_q [BLOCKS];
  logic                pin_q   [BLOCKS];
  logic [AGE_BITS-1:0] age_q   [BLOCKS];
  logic [FILE_W-1:0]   file_q  [BLOCKS];
  logic [BLOCK_W-1:0]  block_q [BLOCKS];

  logic hit_found_q, inv_found_q, best_found_q, pend_q;
  logic [IW-1:0] hit_slot_q, inv_slot_q, best_slot_q, vic_slot_q, pend_slot_q;
  logic                best_dirty_q;
  logic [AGE_BITS-1:0] best_age_q;
  logic [FILE_W-1:0]   best_file_q;
  logic [BLOCK_W-1:0]  best_block_q;
  logic [BLOCK_W-1:0]  pend_block_q;

  logic step, cur_last, cur_match, read_hit, no_victim, push;

  assign step      = !out_full_i;
  assign cur_last  = (cur_q == IW'(BLOCKS - 1));
  assign cur_match = valid_q[cur_q] && (file_q[cur_q] == req_q.file);
  assign read_hit  = (req_q.op == OP_READ) && hit_found_q;
  assign no_victim = !inv_found_q && !best_found_q;

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: begin
        if (req_valid_i) begin
          case (req_i.op)
            OP_READ:  st_d = S_AGE;
            OP_ALLOC: st_d = S_SCAN;
            OP_CLOSE: st_d = S_CSCAN;
            default:  st_d = S_IDLE;
          endcase
        end
      end
      S_AGE:    st_d = S_SCAN;
      S_SCAN:   st_d = cur_last ? S_DECIDE : S_SCAN;
      S_DECIDE: st_d = (read_hit || no_victim) ? S_IDLE : S_FIN;
      S_FIN:    st_d = S_IDLE;
      S_CSCAN:  st_d = cur_last ? S_CEND : S_CSCAN;
      S_CEND:   st_d = S_IDLE;
      default:  st_d = S_IDLE;
    endcase
    if (!step) begin
      st_d = st_q;
    end
  end

  // outputs
  always_comb begin
    push  = 1'b0;
    res_o = '0;
    res_o.kind = K_HIT;
    case (st_q)
      S_DECIDE: begin
        if (read_hit) begin
          push = 1'b1;
          res_o.kind  = K_HIT;
          res_o.slot  = SLOT_W'(hit_slot_q);
          res_o.file  = req_q.file;
          res_o.block = req_q.block;
          res_o.last  = 1'b1;
        end else if (no_victim) begin
          push = 1'b1;
          res_o.kind  = K_NOVICT;
          res_o.file  = req_q.file;
          res_o.block = req_q.block;
          res_o.last  = 1'b1;
        end else if (!inv_found_q && best_dirty_q) begin
          push = 1'b1;
          res_o.kind  = K_WB;
          res_o.slot  = SLOT_W'(best_slot_q);
          res_o.file  = best_file_q;
          res_o.block = best_block_q;
        end
      end
      S_FIN: begin
        push = 1'b1;
        res_o.kind  = (req_q.op == OP_READ) ? K_FILL : K_ALLOC;
        res_o.slot  = SLOT_W'(vic_slot_q);
        res_o.file  = req_q.file;
        res_o.block = req_q.block;
        res_o.last  = 1'b1;
      end
      S_CSCAN: begin
        if (cur_match && dirty_q[cur_q] && pend_q) begin
          push = 1'b1;
          res_o.kind  = K_WB;
          res_o.slot  = SLOT_W'(pend_slot_q);
          res_o.file  = req_q.file;
          res_o.block = pend_block_q;
        end
      end
      S_CEND: begin
        push = 1'b1;
        res_o.file = req_q.file;
        res_o.last = 1'b1;
        if (pend_q) begin
          res_o.kind  = K_WB;
          res_o.slot  = SLOT_W'(pend_slot_q);
          res_o.block = pend_block_q;
        end else begin
          res_o.kind = K_CLOSE;
        end
      end
      default: push = 1'b0;
    endcase
  end

  assign push_o    = push && step;
  assign req_pop_o = (st_q == S_IDLE) && req_valid_i && step;

  // control state and entry flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= S_IDLE;
      cur_q        <= '0;
      hit_found_q  <= 1'b0;
      inv_found_q  <= 1'b0;
      best_found_q <= 1'b0;
      pend_q       <= 1'b0;
      for (int i = 0; i < BLOCKS; i++) begin
        valid_q[i] <= 1'b0;
        dirty_q[i] <= 1'b0;
        pin_q[i]   <= 1'b0;
        age_q[i]   <= '0;
      end
    end else if (step) begin
      st_q <= st_d;
      case (st_q)
        S_IDLE: begin
          cur_q        <= '0;
          hit_found_q  <= 1'b0;
          inv_found_q  <= 1'b0;
          best_found_q <= 1'b0;
          pend_q       <= 1'b0;
        end
        S_AGE: begin
          for (int i = 0; i < BLOCKS; i++) begin
            if (age_q[i] != AGE_MAX) begin
              age_q[i] <= age_q[i] + 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (req_q.op == OP_READ && !hit_found_q && valid_q[cur_q] &&
              file_q[cur_q] == req_q.file && block_q[cur_q] == req_q.block) begin
            hit_found_q <= 1'b1;
          end
          if (!valid_q[cur_q] && !inv_found_q) begin
            inv_found_q <= 1'b1;
          end
          if (!pin_q[cur_q] && (!best_found_q || age_q[cur_q] > best_age_q)) begin
            best_found_q <= 1'b1;
          end
          cur_q <= cur_last ? '0 : cur_q + 1'b1;
        end
        S_DECIDE: begin
          if (read_hit) begin
            age_q[hit_slot_q] <= '0;
            pin_q[hit_slot_q] <= req_q.pin;
            if (req_q.dirty) begin
              dirty_q[hit_slot_q] <= 1'b1;
            end
          end
        end
        S_FIN: begin
          valid_q[vic_slot_q] <= 1'b1;
          age_q[vic_slot_q]   <= '0;
          dirty_q[vic_slot_q] <= req_q.dirty;
          pin_q[vic_slot_q]   <= req_q.pin;
        end
        S_CSCAN: begin
          if (cur_match) begin
            valid_q[cur_q] <= 1'b0;
            dirty_q[cur_q] <= 1'b0;
            pin_q[cur_q]   <= 1'b0;
            age_q[cur_q]   <= '0;
            if (dirty_q[cur_q]) begin
              pend_q <= 1'b1;
            end
          end
          cur_q <= cur_last ? '0 : cur_q + 1'b1;
        end
        default: cur_q <= cur_q;
      endcase
    end
  end

  // payload: request, tags and scan results
  always_ff @(posedge clk_i) begin
    if (step) begin
      case (st_q)
        S_IDLE: begin
          if (req_valid_i) begin
            req_q <= req_i;
          end
        end
        S_SCAN: begin
          if (req_q.op == OP_READ && !hit_found_q && valid_q[cur_q] &&
              file_q[cur_q] == req_q.file && block_q[cur_q] == req_q.block) begin
            hit_slot_q <= cur_q;
          end
          if (!valid_q[cur_q] && !inv_found_q) begin
            inv_slot_q <= cur_q;
          end
          if (!pin_q[cur_q] && (!best_found_q || age_q[cur_q] > best_age_q)) begin
            best_slot_q  <= cur_q;
            best_age_q   <= age_q[cur_q];
            best_dirty_q <= valid_q[cur_q] && dirty_q[cur_q];
            best_file_q  <= file_q[cur_q];
            best_block_q <= block_q[cur_q];
          end
        end
        S_DECIDE: begin
          vic_slot_q <= inv_found_q ? inv_slot_q : best_slot_q;
        end
        S_FIN: begin
          file_q[vic_slot_q]  <= req_q.file;
          block_q[vic_slot_q] <= req_q.block;
        end
        S_CSCAN: begin
          if (cur_match && dirty_q[cur_q]) begin
            pend_slot_q  <= cur_q;
            pend_block_q <= block_q[cur_q];
          end
        end
        default: vic_slot_q <= vic_slot_q;
      endcase
    end
  end

  `ASSERT_NEVER(a_push_full, clk_i, rst_ni, push_o && out_full_i)
  `ASSERT_IMPL(a_pop_idle, clk_i, rst_ni, req_pop_o |-> st_q == S_IDLE)
  `ASSERT_IMPL(a_idle_quiet, clk_i, rst_ni, st_q == S_IDLE |-> !push_o)
  `ASSERT_IMPL(a_fin_last, clk_i, rst_ni, (st_q == S_FIN) && step |=> st_q == S_IDLE)

endmodule

// ===== hdl/lru_block_buffer_pool.sv =====
// lru block buffer pool: tag and replacement control for a pool of disk-block buffers
// request side is a queue: drive cmd/file/block/flags and raise push; the word is
//   taken at a clock edge with push high and full low. unknown commands are dropped
// result side is a queue: while empty is low the oldest result word sits on the
//   result ports; raise pop to take it. a request gives one or more words, the
//   final one with last set
// a two-word request queue feeds a sequencer that walks the entries one per cycle while
//   the result queue has room, then results go into a two-word result queue
// steps: a read pops the request, ages the entries, scans every entry, decides and,
//   on a miss with a victim, fills; an allocate does the same without aging; a close
//   pops, scans every entry and ends; a new request is popped only back in idle
// reset clears every valid, dirty, pin bit and age and both queues; no clearing pass
// when the result queue is full the sequencer freezes, the request queue fills and
//   full rises; nothing is dropped
module lru_block_buffer_pool #(
  parameter int BLOCKS   = lbbp_pkg::BLOCKS_DEF,
  parameter int AGE_BITS = lbbp_pkg::AGE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [lbbp_pkg::CMD_W-1:0]   cmd_i,
  input  logic [lbbp_pkg::FILE_W-1:0]  file_id_i,
  input  logic [lbbp_pkg::BLOCK_W-1:0] block_num_i,
  input  logic                         mark_dirty_i,
  input  logic                         pin_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [lbbp_pkg::KIND_W-1:0]  kind_o,
  output logic [lbbp_pkg::SLOT_W-1:0]  slot_o,
  output logic [lbbp_pkg::FILE_W-1:0]  out_file_o,
  output logic [lbbp_pkg::BLOCK_W-1:0] out_block_o,
  output logic                         last_o
);
  import lbbp_pkg::*;

  req_t req;
  logic req_valid, req_pop;
  logic res_push, res_full;
  res_t res_in, res_out;
  logic [$bits(res_t)-1:0] res_rdata;

  // front: decode and queue requests
  lbbp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .cmd_i        (cmd_i),
    .file_id_i    (file_id_i),
    .block_num_i  (block_num_i),
    .mark_dirty_i (mark_dirty_i),
    .pin_i        (pin_i),
    .req_valid_o  (req_valid),
    .req_o        (req),
    .req_pop_i    (req_pop)
  );

  // back: entry table and scan sequencer
  lbbp_back #(
    .BLOCKS   (BLOCKS),
    .AGE_BITS (AGE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_pop_o   (req_pop),
    .out_full_i  (res_full),
    .push_o      (res_push),
    .res_o       (res_in)
  );

  // result queue decouples the consumer from the sequencer
  lbbp_fifo #(
    .W     ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .rd_i    (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign res_out     = res_t'(res_rdata);
  assign kind_o      = res_out.kind;
  assign slot_o      = res_out.slot;
  assign out_file_o  = res_out.file;
  assign out_block_o = res_out.block;
  assign last_o      = res_out.last;

endmodule
